>>> rtl/ptt_pkg.sv
`timescale 1ns / 1ps
// Package for the periodic timer table: reset values, codes and the
// sequencer state type. No dependencies.
package ptt_pkg;

  localparam int CHANNEL_COUNT_DEF = 16;

  localparam logic [30:0] MIN_SLEEP_RST = 31'd1000;
  localparam logic [31:0] SLEEP_CAP     = 32'h8000_0000;

  localparam logic ACT_PROGRAM = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  localparam logic KIND_DUE   = 1'b0;
  localparam logic KIND_SLEEP = 1'b1;

  localparam logic CFG_SLEEP_ENABLE = 1'b0;
  localparam logic CFG_MIN_SLEEP    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_EMIT,
    S_DIV,
    S_MUL,
    S_ADD,
    S_WRITE,
    S_END
  } ptt_state_t;

endpackage

>>> rtl/ptt_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/ptt_div.sv
`timescale 1ns / 1ps
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// No dependencies; the divisor must be non-zero.
module ptt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]} - {1'b0, dvs_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> rtl/periodic_timer_table.sv
`timescale 1ns / 1ps
// Periodic timer table. A program transfer writes a channel's due time and interval.
// A tick walks every channel through the due-time and interval memories: read, evaluate
// and write for a channel that is not due, plus an emit step for a due channel, plus
// divide, multiply and add steps when missed periods are skipped, the divide waiting on
// the serial divider. The end of the walk sends the remaining reports, with any result
// stall holding them. Depends on ptt_pkg, ptt_ram and ptt_div.
module periodic_timer_table import ptt_pkg::*; #(
  parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [30:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [3:0]  in_channel,
  input  logic [31:0] in_time_value,
  input  logic [31:0] in_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [3:0]  out_due_channel,
  output logic        out_sleep_ok,
  output logic [31:0] out_sleep_time,
  output logic        out_last
);

  localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(CHANNEL_COUNT - 1);

  ptt_state_t state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] due_r, due_nxt;
  logic [31:0] iv_r, iv_nxt;
  logic [31:0] t_r, t_nxt;
  logic [31:0] new_due_r, new_due_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic [31:0] best_r, best_nxt;
  logic        ok_r, ok_nxt;
  logic        hit_r, hit_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [AW-1:0] pend_ch_r, pend_ch_nxt;
  logic [CHANNEL_COUNT-1:0] valid_r, valid_nxt;
  logic        sleep_en_r;
  logic [30:0] min_sleep_r;

  logic        out_valid_r, out_valid_nxt;
  logic        out_kind_r, out_kind_nxt;
  logic [3:0]  out_ch_r, out_ch_nxt;
  logic        out_ok_r, out_ok_nxt;
  logic [31:0] out_time_r, out_time_nxt;
  logic        out_last_r, out_last_nxt;

  logic          due_we, iv_we;
  logic [AW-1:0] waddr;
  logic [31:0]   due_wdata;
  logic [31:0]   rd_due, rd_iv;
  logic          div_start, div_done;
  logic [31:0]   div_dividend, div_quo;
  logic          out_free;
  logic [31:0]   ev_due, ev_iv, ev_diff, adv, fold_delta;

  ptt_ram #(.WIDTH(32), .DEPTH(CHANNEL_COUNT)) u_due_ram (
    .clk(clk), .we(due_we), .waddr(waddr), .wdata(due_wdata),
    .raddr(idx_r), .rdata(rd_due)
  );

  ptt_ram #(.WIDTH(32), .DEPTH(CHANNEL_COUNT)) u_iv_ram (
    .clk(clk), .we(iv_we), .waddr(waddr), .wdata(in_period),
    .raddr(idx_r), .rdata(rd_iv)
  );

  ptt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(iv_r), .done(div_done), .quotient(div_quo)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign ev_due   = valid_r[idx_r] ? rd_due : '0;
  assign ev_iv    = valid_r[idx_r] ? rd_iv : '0;
  assign ev_diff  = ev_due - now_r;
  assign adv      = due_r + iv_r;
  assign div_dividend = now_r - adv;
  assign fold_delta   = new_due_r - now_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    now_nxt       = now_r;
    due_nxt       = due_r;
    iv_nxt        = iv_r;
    t_nxt         = t_r;
    new_due_nxt   = new_due_r;
    prod_nxt      = prod_r;
    best_nxt      = best_r;
    ok_nxt        = ok_r;
    hit_nxt       = hit_r;
    pend_v_nxt    = pend_v_r;
    pend_ch_nxt   = pend_ch_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_ch_nxt    = out_ch_r;
    out_ok_nxt    = out_ok_r;
    out_time_nxt  = out_time_r;
    out_last_nxt  = out_last_r;
    due_we        = 1'b0;
    iv_we         = 1'b0;
    waddr         = idx_r;
    due_wdata     = new_due_r;
    div_start     = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_PROGRAM) begin
            if ({5'd0, in_channel} < 9'(CHANNEL_COUNT)) begin
              due_we    = 1'b1;
              iv_we     = 1'b1;
              waddr     = AW'(in_channel);
              due_wdata = in_time_value;
              valid_nxt[AW'(in_channel)] = 1'b1;
            end
          end else begin
            now_nxt    = in_time_value;
            idx_nxt    = '0;
            best_nxt   = SLEEP_CAP;
            ok_nxt     = 1'b1;
            pend_v_nxt = 1'b0;
            state_nxt  = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        due_nxt = ev_due;
        iv_nxt  = ev_iv;
        if (ev_due != '0 && (ev_diff[31] || ev_diff == '0)) begin
          hit_nxt   = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          hit_nxt     = 1'b0;
          new_due_nxt = ev_due;
          state_nxt   = S_WRITE;
        end
      end
      S_EMIT: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_DUE;
            out_ch_nxt    = 4'(pend_ch_r);
            out_ok_nxt    = 1'b0;
            out_time_nxt  = '0;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_ch_nxt = idx_r;
          t_nxt       = adv;
          if (iv_r == '0) begin
            new_due_nxt = '0;
            state_nxt   = S_WRITE;
          end else if (adv[31:0] - now_r >= SLEEP_CAP) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            new_due_nxt = adv;
            state_nxt   = S_WRITE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = (div_quo + 32'd1) * iv_r;
        state_nxt = S_ADD;
      end
      S_ADD: begin
        new_due_nxt = t_r + prod_r;
        state_nxt   = S_WRITE;
      end
      S_WRITE: begin
        due_we = hit_r;
        if (new_due_r != '0) begin
          if ($signed(fold_delta) < $signed({1'b0, min_sleep_r})) begin
            ok_nxt = 1'b0;
          end else if (fold_delta < best_r) begin
            best_nxt = fold_delta;
          end
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_END;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_READ;
        end
      end
      S_END: begin
        if (out_free) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_kind_nxt  = KIND_DUE;
            out_ch_nxt    = 4'(pend_ch_r);
            out_ok_nxt    = 1'b0;
            out_time_nxt  = '0;
            out_last_nxt  = !sleep_en_r;
            pend_v_nxt    = 1'b0;
            if (!sleep_en_r) begin
              state_nxt = S_IDLE;
            end
          end else begin
            if (sleep_en_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_SLEEP;
              out_ch_nxt    = '0;
              out_ok_nxt    = ok_r;
              out_time_nxt  = ok_r ? best_r : '0;
              out_last_nxt  = 1'b1;
            end
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      sleep_en_r  <= 1'b0;
      min_sleep_r <= MIN_SLEEP_RST;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SLEEP_ENABLE: sleep_en_r  <= cfg_wdata[0];
          CFG_MIN_SLEEP:    min_sleep_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    idx_r      <= idx_nxt;
    now_r      <= now_nxt;
    due_r      <= due_nxt;
    iv_r       <= iv_nxt;
    t_r        <= t_nxt;
    new_due_r  <= new_due_nxt;
    prod_r     <= prod_nxt;
    best_r     <= best_nxt;
    ok_r       <= ok_nxt;
    hit_r      <= hit_nxt;
    pend_ch_r  <= pend_ch_nxt;
    out_kind_r <= out_kind_nxt;
    out_ch_r   <= out_ch_nxt;
    out_ok_r   <= out_ok_nxt;
    out_time_r <= out_time_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_due_channel = out_ch_r;
  assign out_sleep_ok    = out_ok_r;
  assign out_sleep_time  = out_time_r;
  assign out_last        = out_last_r;

endmodule

>>> rtl/ptt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the periodic timer table, bound to the top level.
// Depends on ptt_pkg and periodic_timer_table.
module ptt_port_checks import ptt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_action,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [3:0]  out_due_channel,
  input logic        out_sleep_ok,
  input logic [31:0] out_sleep_time,
  input logic        out_last
);

  // A tick transfer starts a walk, so the input is held off afterwards.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_TICK |=> in_stall)
    else $error("tick transfer not followed by a busy walk");

  a_sleep_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SLEEP |-> out_last && out_due_channel == 4'd0)
    else $error("sleep report is not the final result");

  a_due_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DUE |-> !out_sleep_ok && out_sleep_time == 32'd0)
    else $error("due report carries sleep fields");

  a_sleep_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SLEEP |->
      out_sleep_time <= SLEEP_CAP && (out_sleep_ok || out_sleep_time == 32'd0))
    else $error("sleep time out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_due_channel) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind periodic_timer_table ptt_port_checks u_ptt_port_checks (.*);
